### design/multi_channel_soft_timer_bank_assert.svh
// assertion macros used by the timer bank rtl
`ifndef MULTI_CHANNEL_SOFT_TIMER_BANK_ASSERT_SVH
`define MULTI_CHANNEL_SOFT_TIMER_BANK_ASSERT_SVH

`ifndef SYNTHESIS
`define MCST_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("timer bank check failed");
`define MCST_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) pre |=> post) \
        else $error("timer bank check failed");
`else
`define MCST_ASSERT(lbl, prop)
`define MCST_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

### design/mcst_pkg.sv
`default_nettype none

package mcst_pkg;

    localparam int TIMER_SLOTS_DEF = 8;

    typedef logic [2:0]  t_func;
    typedef logic [7:0]  t_index;
    typedef logic [31:0] t_ticks;
    typedef logic [1:0]  t_status;
    typedef logic [1:0]  t_mode;

    localparam t_func FUNC_CREATE  = 3'd0;
    localparam t_func FUNC_START   = 3'd1;
    localparam t_func FUNC_STOP    = 3'd2;
    localparam t_func FUNC_PAUSE   = 3'd3;
    localparam t_func FUNC_RESUME  = 3'd4;
    localparam t_func FUNC_RESET   = 3'd5;
    localparam t_func FUNC_SET_DUR = 3'd6;
    localparam t_func FUNC_TICK    = 3'd7;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_BAD_ID   = 2'd1;
    localparam t_status ST_FULL     = 2'd2;
    localparam t_status ST_ZERO_DUR = 2'd3;

    localparam t_mode MODE_STOPPED = 2'd0;
    localparam t_mode MODE_RUNNING = 2'd1;
    localparam t_mode MODE_PAUSED  = 2'd2;

    localparam logic KIND_ACK    = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    localparam t_index NO_INDEX = 8'hFF;

    // one timer slot as kept in the slot memory
    typedef struct packed {
        t_ticks period;
        t_ticks stamp;
        t_mode  mode;
        logic   reload;
    } t_entry;

endpackage

`default_nettype wire

### design/mcst_ifs.sv
`default_nettype none

interface mcst_cmd_if;
    import mcst_pkg::*;

    logic   valid;
    logic   ready;
    t_func  func;
    t_index timer_id;
    t_ticks duration;
    logic   auto_reload;

    modport source (output valid, output func, output timer_id, output duration,
                    output auto_reload, input ready);
    modport sink (input valid, input func, input timer_id, input duration,
                  input auto_reload, output ready);
endinterface

interface mcst_res_if;
    import mcst_pkg::*;

    logic    valid;
    logic    ready;
    logic    kind;
    t_index  timer_index;
    t_status status;
    logic    last;

    modport source (output valid, output kind, output timer_index, output status,
                    output last, input ready);
    modport sink (input valid, input kind, input timer_index, input status,
                  input last, output ready);
endinterface

`default_nettype wire

### design/multi_channel_soft_timer_bank.sv
// create and rejected commands go from decode to the ack, other commands through the elapsed
// and compare states first; ready returns with the ack, so no command item is taken while one
// is in flight; a tick with no slot allocated ends at decode, otherwise each slot is read and
// a running slot also compared; a result that meets a full output register adds its stall
// synchronous active-low reset clears the allocation count, time, scan and output state;
// slot contents are not cleared, since a slot is only read after create writes it
`default_nettype none

module multi_channel_soft_timer_bank #(
    parameter int TIMER_SLOTS = mcst_pkg::TIMER_SLOTS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    mcst_cmd_if.sink   i_cmd,
    mcst_res_if.source o_res
);
    import mcst_pkg::*;

    localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    t_entry        w_wr_data;
    logic [AW-1:0] w_rd_addr;
    t_entry        w_rd_data;
    t_ticks        w_sub_a;
    t_ticks        w_sub_b;
    t_ticks        w_sub_diff;
    logic          w_sub_borrow;

    mcst_sub_unit u_sub (
        .i_a      (w_sub_a),
        .i_b      (w_sub_b),
        .o_diff   (w_sub_diff),
        .o_borrow (w_sub_borrow)
    );

    mcst_timer_mem #(
        .SLOTS (TIMER_SLOTS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    mcst_seq #(
        .SLOTS (TIMER_SLOTS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .o_res        (o_res),
        .o_wr_en      (w_wr_en),
        .o_wr_addr    (w_wr_addr),
        .o_wr_data    (w_wr_data),
        .o_rd_addr    (w_rd_addr),
        .i_rd_data    (w_rd_data),
        .o_sub_a      (w_sub_a),
        .o_sub_b      (w_sub_b),
        .i_sub_diff   (w_sub_diff),
        .i_sub_borrow (w_sub_borrow)
    );

endmodule

`default_nettype wire

### design/mcst_sub_unit.sv
`default_nettype none

// shared 32-bit subtractor: elapsed time, remaining time, time increment
module mcst_sub_unit (
    input  wire mcst_pkg::t_ticks i_a,
    input  wire mcst_pkg::t_ticks i_b,
    output mcst_pkg::t_ticks      o_diff,
    output logic                  o_borrow
);
    import mcst_pkg::*;

    logic [32:0] w_full;

    assign w_full   = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff   = w_full[31:0];
    assign o_borrow = w_full[32];

endmodule

`default_nettype wire

### design/mcst_timer_mem.sv
`default_nettype none

module mcst_timer_mem #(
    parameter  int SLOTS = mcst_pkg::TIMER_SLOTS_DEF,
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire                   i_clk,
    input  wire                   i_wr_en,
    input  wire [AW-1:0]          i_wr_addr,
    input  wire mcst_pkg::t_entry i_wr_data,
    input  wire [AW-1:0]          i_rd_addr,
    output mcst_pkg::t_entry      o_rd_data
);
    import mcst_pkg::*;

    t_entry r_mem [SLOTS];
    t_entry r_rd_data;

    // a slot is always written by create before its contents are used
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### design/mcst_seq.sv
`default_nettype none
`include "multi_channel_soft_timer_bank_assert.svh"

module mcst_seq #(
    parameter  int SLOTS = mcst_pkg::TIMER_SLOTS_DEF,
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int CW    = $clog2(SLOTS + 1)
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    mcst_cmd_if.sink         i_cmd,
    mcst_res_if.source       o_res,
    output logic             o_wr_en,
    output logic [AW-1:0]    o_wr_addr,
    output mcst_pkg::t_entry o_wr_data,
    output logic [AW-1:0]    o_rd_addr,
    input  wire mcst_pkg::t_entry i_rd_data,
    output mcst_pkg::t_ticks o_sub_a,
    output mcst_pkg::t_ticks o_sub_b,
    input  wire mcst_pkg::t_ticks i_sub_diff,
    input  wire              i_sub_borrow
);
    import mcst_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_EL     = 4'd2;
    localparam logic [3:0] S_CMP    = 4'd3;
    localparam logic [3:0] S_EMIT   = 4'd4;
    localparam logic [3:0] S_TRD    = 4'd5;
    localparam logic [3:0] S_TEL    = 4'd6;
    localparam logic [3:0] S_TCMP   = 4'd7;
    localparam logic [3:0] S_TEND   = 4'd8;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    t_ticks        r_now, n_now;
    logic [AW-1:0] r_scan, n_scan;
    logic          r_pend_v, n_pend_v;
    logic [AW-1:0] r_pend, n_pend;
    t_ticks        r_el, n_el;

    t_func         r_func, n_func;
    t_index        r_id, n_id;
    t_ticks        r_dur, n_dur;
    logic          r_reload, n_reload;
    t_index        r_ack_idx, n_ack_idx;
    t_status       r_ack_status, n_ack_status;

    logic          r_out_valid, n_out_valid;
    logic          r_kind, n_kind;
    t_index        r_idx, n_idx;
    t_status       r_status, n_status;
    logic          r_last, n_last;

    logic          w_out_free;
    logic          w_expired;
    logic [CW-1:0] w_scan_inc;
    t_entry        w_upd;

    assign w_out_free = !r_out_valid || o_res.ready;
    // elapsed >= period exactly when period - elapsed borrows or is zero
    assign w_expired  = i_sub_borrow || (i_sub_diff == '0);
    assign w_scan_inc = CW'(r_scan) + CW'(1);

    assign i_cmd.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.kind        = r_kind;
    assign o_res.timer_index = r_idx;
    assign o_res.status      = r_status;
    assign o_res.last        = r_last;

    assign o_rd_addr = (r_func == FUNC_TICK) ? r_scan : r_id[AW-1:0];

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_now        = r_now;
        n_scan       = r_scan;
        n_pend_v     = r_pend_v;
        n_pend       = r_pend;
        n_el         = r_el;
        n_func       = r_func;
        n_id         = r_id;
        n_dur        = r_dur;
        n_reload     = r_reload;
        n_ack_idx    = r_ack_idx;
        n_ack_status = r_ack_status;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_kind       = r_kind;
        n_idx        = r_idx;
        n_status     = r_status;
        n_last       = r_last;
        o_wr_en      = 1'b0;
        o_wr_addr    = o_rd_addr;
        o_wr_data    = i_rd_data;
        o_sub_a      = r_now;
        o_sub_b      = i_rd_data.stamp;
        w_upd        = i_rd_data;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_func   = i_cmd.func;
                    n_id     = i_cmd.timer_id;
                    n_dur    = i_cmd.duration;
                    n_reload = i_cmd.auto_reload;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                if (r_func == FUNC_TICK) begin
                    // now - (-1) is now + 1
                    o_sub_b  = '1;
                    n_now    = i_sub_diff;
                    n_scan   = '0;
                    n_pend_v = 1'b0;
                    n_state  = (r_count == '0) ? S_IDLE : S_TRD;
                end else if (r_func == FUNC_CREATE) begin
                    n_state = S_EMIT;
                    if (r_count == CW'(SLOTS)) begin
                        n_ack_idx    = NO_INDEX;
                        n_ack_status = ST_FULL;
                    end else if (r_dur == '0) begin
                        n_ack_idx    = NO_INDEX;
                        n_ack_status = ST_ZERO_DUR;
                    end else begin
                        o_wr_en          = 1'b1;
                        o_wr_addr        = r_count[AW-1:0];
                        o_wr_data.period = r_dur;
                        o_wr_data.stamp  = '0;
                        o_wr_data.mode   = MODE_STOPPED;
                        o_wr_data.reload = r_reload;
                        n_count          = r_count + CW'(1);
                        n_ack_idx        = 8'(r_count);
                        n_ack_status     = ST_OK;
                    end
                end else if (r_id >= 8'(r_count)) begin
                    n_ack_idx    = r_id;
                    n_ack_status = ST_BAD_ID;
                    n_state      = S_EMIT;
                end else begin
                    n_state = S_EL;
                end
            end
            S_EL: begin
                n_el    = i_sub_diff;
                n_state = S_CMP;
            end
            S_CMP: begin
                o_sub_a = i_rd_data.period;
                o_sub_b = r_el;
                unique case (r_func)
                    FUNC_START: begin
                        w_upd.stamp = r_now;
                        w_upd.mode  = MODE_RUNNING;
                    end
                    FUNC_STOP: begin
                        w_upd.mode = MODE_STOPPED;
                    end
                    FUNC_PAUSE: begin
                        if (i_rd_data.mode == MODE_RUNNING) begin
                            w_upd.period = i_sub_borrow ? '0 : i_sub_diff;
                            w_upd.mode   = MODE_PAUSED;
                        end
                    end
                    FUNC_RESUME: begin
                        if (i_rd_data.mode == MODE_PAUSED) begin
                            w_upd.stamp = r_now;
                            w_upd.mode  = MODE_RUNNING;
                        end
                    end
                    FUNC_RESET: begin
                        w_upd.stamp = r_now;
                        if (i_rd_data.mode != MODE_STOPPED) begin
                            w_upd.mode = MODE_RUNNING;
                        end
                    end
                    default: begin
                        w_upd.period = r_dur;
                        if (i_rd_data.mode == MODE_RUNNING) begin
                            w_upd.stamp = r_now;
                        end
                    end
                endcase
                o_wr_en      = 1'b1;
                o_wr_data    = w_upd;
                n_ack_idx    = r_id;
                n_ack_status = ST_OK;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_ACK;
                    n_idx       = r_ack_idx;
                    n_status    = r_ack_status;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_TRD: begin
                n_state = S_TEL;
            end
            S_TEL: begin
                if (i_rd_data.mode == MODE_RUNNING) begin
                    n_el    = i_sub_diff;
                    n_state = S_TCMP;
                end else if (w_scan_inc == r_count) begin
                    n_state = S_TEND;
                end else begin
                    n_scan  = r_scan + AW'(1);
                    n_state = S_TRD;
                end
            end
            S_TCMP: begin
                o_sub_a = i_rd_data.period;
                o_sub_b = r_el;
                // hold the expiry back until the previous one has left
                if (!w_expired || !r_pend_v || w_out_free) begin
                    if (w_expired) begin
                        if (r_pend_v) begin
                            n_out_valid = 1'b1;
                            n_kind      = KIND_EXPIRY;
                            n_idx       = 8'(r_pend);
                            n_status    = ST_OK;
                            n_last      = 1'b0;
                        end
                        if (i_rd_data.reload) begin
                            w_upd.stamp = r_now;
                        end else begin
                            w_upd.mode = MODE_STOPPED;
                        end
                        o_wr_en   = 1'b1;
                        o_wr_data = w_upd;
                        n_pend_v  = 1'b1;
                        n_pend    = r_scan;
                    end
                    if (w_scan_inc == r_count) begin
                        n_state = S_TEND;
                    end else begin
                        n_scan  = r_scan + AW'(1);
                        n_state = S_TRD;
                    end
                end
            end
            S_TEND: begin
                if (!r_pend_v) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_EXPIRY;
                    n_idx       = 8'(r_pend);
                    n_status    = ST_OK;
                    n_last      = 1'b1;
                    n_pend_v    = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_now       <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_now       <= n_now;
            r_pend_v    <= n_pend_v;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan       <= n_scan;
        r_pend       <= n_pend;
        r_el         <= n_el;
        r_func       <= n_func;
        r_id         <= n_id;
        r_dur        <= n_dur;
        r_reload     <= n_reload;
        r_ack_idx    <= n_ack_idx;
        r_ack_status <= n_ack_status;
        r_kind       <= n_kind;
        r_idx        <= n_idx;
        r_status     <= n_status;
        r_last       <= n_last;
    end

    // scan states are S_TRD and above
    `MCST_ASSERT(a_count_in_range, r_count <= CW'(SLOTS))
    `MCST_ASSERT_NEXT(a_count_grows, 1'b1, r_count >= $past(r_count))
    `MCST_ASSERT(a_pend_only_in_tick, !r_pend_v || r_state >= S_TRD)
    `MCST_ASSERT(a_update_allocated, !(o_wr_en && r_state != S_DECODE) || CW'(o_wr_addr) < r_count)

endmodule

`default_nettype wire
